FILE: hdl/msfbr_pkg.sv
// Shared types and constants for the spanning forest budget removal block.
package msfbr_pkg;

  localparam int MaxNodesDef   = 32;
  localparam int MaxEdgesDef   = 32;
  localparam int WeightBitsDef = 32;
  localparam int VertW   = 6;
  localparam int WInW    = 32;
  localparam int CostW   = 64;
  localparam int BudgetW = 63;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgNodeCount  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCostBudget = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SORT,
    ST_UF_FIND_A,
    ST_UF_FIND_B,
    ST_UF_JOIN,
    ST_SCAN,
    ST_EMIT,
    ST_WAIT_OUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic sort_step;
    logic find_a;
    logic find_b;
    logic join_step;
    logic scan_step;
    logic emit_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic clear_done;
    logic sort_done;
    logic find_done;
    logic uf_done;
    logic scan_done;
    logic emit_last;
  } stat_t;

endpackage

FILE: hdl/msfbr_datapath.sv
// Edge store, insertion sort, union-find, budget scan and result selection.
module msfbr_datapath #(
  parameter int MAX_NODES   = msfbr_pkg::MaxNodesDef,
  parameter int MAX_EDGES   = msfbr_pkg::MaxEdgesDef,
  parameter int WEIGHT_BITS = msfbr_pkg::WeightBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msfbr_pkg::cmd_t               cmd,
  output msfbr_pkg::stat_t              stat,
  input  logic [msfbr_pkg::VertW-1:0]   node_count,
  input  logic [msfbr_pkg::BudgetW-1:0] cost_budget,
  input  logic [msfbr_pkg::VertW-1:0]   end_one,
  input  logic [msfbr_pkg::VertW-1:0]   end_two,
  input  logic [msfbr_pkg::WInW-1:0]    edge_weight,
  output logic                          has_edge,
  output logic [msfbr_pkg::VertW-1:0]   chosen_number,
  output logic [msfbr_pkg::VertW-1:0]   chosen_total,
  output logic                          run_end
);
  localparam int VW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int NCW = (msfbr_pkg::VertW > SW) ? msfbr_pkg::VertW : SW;

  logic [WEIGHT_BITS-1:0] wmem [MAX_EDGES];
  logic [VW-1:0]          ea   [MAX_EDGES];
  logic [VW-1:0]          eb   [MAX_EDGES];
  logic [EW-1:0]          ord  [MAX_EDGES];
  logic [MAX_EDGES-1:0]   remv;
  logic [MAX_EDGES-1:0]   chosen;
  logic [VW-1:0]          lead [MAX_NODES];
  logic [SW-1:0]          size [MAX_NODES];

  logic [CW-1:0] loaded;
  logic [CW-1:0] si;
  logic [CW-1:0] sj;
  logic [EW-1:0] ins;
  logic          sorting_shift;
  logic [VW-1:0] cur;
  logic [VW-1:0] ra;
  logic [VW-1:0] rb;
  logic [VW-1:0] clr;
  logic [msfbr_pkg::CostW-1:0] spent;
  logic [CW-1:0] total;
  logic [CW-1:0] emitted;
  logic [CW-1:0] ei;

  logic [NCW-1:0] n_eff;
  logic [NCW-1:0] va;
  logic [NCW-1:0] vb;
  logic [EW-1:0]  cur_edge;
  logic [VW-1:0]  big;
  logic [VW-1:0]  sml;

  // scan works on order slot si-1
  logic [EW-1:0] sedge;
  logic [msfbr_pkg::CostW:0] sf2;
  logic [msfbr_pkg::CostW-1:0] sum_sat2;
  logic          fits;

  // next chosen edge at or after ei
  logic [CW-1:0] nxt_idx;
  logic [CW-1:0] pos;

  always_comb begin
    n_eff = NCW'(node_count);
    if (n_eff == '0) n_eff = NCW'(1);
    if (n_eff > NCW'(MAX_NODES)) n_eff = NCW'(MAX_NODES);
    va = NCW'(end_one);
    vb = NCW'(end_two);
    if (va == '0) va = NCW'(1);
    if (va > n_eff) va = n_eff;
    if (vb == '0) vb = NCW'(1);
    if (vb > n_eff) vb = n_eff;
  end

  assign cur_edge  = ord[si[EW-1:0]];
  assign big = (size[ra] > size[rb]) ? ra : rb;
  assign sml = (size[ra] > size[rb]) ? rb : ra;

  assign sedge = ord[si[EW-1:0]-EW'(1)];
  assign sf2 = {1'b0, spent} + (msfbr_pkg::CostW+1)'(wmem[sedge]);
  assign sum_sat2 = sf2[msfbr_pkg::CostW] ? '1 : sf2[msfbr_pkg::CostW-1:0];
  assign fits = (sum_sat2 <= msfbr_pkg::CostW'(cost_budget));

  always_comb begin
    pos = CW'(MAX_EDGES);
    for (int k = MAX_EDGES - 1; k >= 0; k--) begin
      if (chosen[k] && CW'(k) >= ei) pos = CW'(k);
    end
    nxt_idx = pos + CW'(1);
  end

  assign stat.full       = (loaded >= CW'(MAX_EDGES));
  assign stat.clear_done = (clr == VW'(MAX_NODES - 1));
  assign stat.sort_done  = (si >= loaded) && !sorting_shift;
  assign stat.find_done  = (lead[cur] == cur);
  assign stat.uf_done    = (si >= loaded);
  assign stat.scan_done  = (si == '0);
  assign stat.emit_last  = (total == '0) || (emitted + CW'(1) == total);

  always_ff @(posedge clk) begin
    if (cmd.load && !stat.full) begin
      wmem[loaded[EW-1:0]] <= WEIGHT_BITS'(edge_weight);
      ea[loaded[EW-1:0]]   <= VW'(va - NCW'(1));
      eb[loaded[EW-1:0]]   <= VW'(vb - NCW'(1));
    end
    if (cmd.clear) begin
      lead[clr] <= clr;
      size[clr] <= SW'(1);
    end
    if (cmd.sort_step && !(si >= loaded && !sorting_shift)) begin
      if (!sorting_shift) begin
        ins <= si[EW-1:0];
        sj  <= si;
      end else if (sj != '0 && wmem[ord[sj[EW-1:0]-EW'(1)]] < wmem[ins]) begin
        ord[sj[EW-1:0]] <= ord[sj[EW-1:0]-EW'(1)];
        sj <= sj - CW'(1);
      end else begin
        ord[sj[EW-1:0]] <= ins;
      end
    end
    if (cmd.find_a && lead[cur] == cur) ra <= cur;
    if (cmd.find_b && lead[cur] == cur) rb <= cur;
    if (cmd.join_step) begin
      remv[si[EW-1:0]] <= (ra == rb);
      if (ra != rb) begin
        lead[sml] <= big;
        size[big] <= size[big] + size[sml];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      loaded <= '0;
      clr <= '0;
      si <= '0;
      sorting_shift <= 1'b0;
      spent <= '0;
      chosen <= '0;
      total <= '0;
      emitted <= '0;
      ei <= '0;
      cur <= '0;
    end else begin
      if (cmd.load && !stat.full) loaded <= loaded + CW'(1);
      if (cmd.clear) clr <= clr + VW'(1);
      if (cmd.sort_step && !(si >= loaded && !sorting_shift)) begin
        if (!sorting_shift) sorting_shift <= 1'b1;
        else if (!(sj != '0 && wmem[ord[sj[EW-1:0]-EW'(1)]] < wmem[ins])) begin
          sorting_shift <= 1'b0;
          si <= si + CW'(1);
        end
      end
      if (cmd.sort_step && stat.sort_done) begin
        si <= '0;
        cur <= ea[ord[0]];
      end
      if (cmd.find_a) begin
        if (lead[cur] != cur) cur <= lead[cur];
        else cur <= eb[cur_edge];
      end
      if (cmd.find_b && lead[cur] != cur) cur <= lead[cur];
      if (cmd.join_step) begin
        if (si + CW'(1) < loaded) cur <= ea[ord[si[EW-1:0]+EW'(1)]];
        si <= si + CW'(1);
      end
      if (cmd.scan_step && si != '0) begin
        if (remv[si[EW-1:0]-EW'(1)] && fits) begin
          spent <= sum_sat2;
          chosen[ord[si[EW-1:0]-EW'(1)]] <= 1'b1;
          total <= total + CW'(1);
        end
        si <= si - CW'(1);
      end
      if (cmd.emit_step) begin
        if (total != '0) begin
          emitted <= emitted + CW'(1);
          ei <= nxt_idx;
        end
      end
    end
  end

  assign has_edge      = (total != '0);
  assign chosen_number = (total != '0) ? msfbr_pkg::VertW'(pos + CW'(1)) : '0;
  assign chosen_total  = msfbr_pkg::VertW'(total);
  assign run_end       = stat.emit_last;
endmodule

FILE: hdl/msfbr_ctrl.sv
// Sequencing state machine for load, sort, union-find, scan and emit.
module msfbr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              in_last,
  input  logic              out_fire,
  input  msfbr_pkg::stat_t  stat,
  output msfbr_pkg::cmd_t   cmd,
  output logic              in_ready,
  output logic              out_valid
);
  msfbr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= msfbr_pkg::ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      msfbr_pkg::ST_LOAD:      if (in_fire && in_last) state_next = msfbr_pkg::ST_CLEAR;
      msfbr_pkg::ST_CLEAR:     if (stat.clear_done) state_next = msfbr_pkg::ST_SORT;
      msfbr_pkg::ST_SORT:      if (stat.sort_done) state_next = msfbr_pkg::ST_UF_FIND_A;
      msfbr_pkg::ST_UF_FIND_A: if (stat.find_done) state_next = msfbr_pkg::ST_UF_FIND_B;
      msfbr_pkg::ST_UF_FIND_B: if (stat.find_done) state_next = msfbr_pkg::ST_UF_JOIN;
      msfbr_pkg::ST_UF_JOIN:   state_next = msfbr_pkg::ST_UF_FIND_A;
      msfbr_pkg::ST_SCAN:      if (stat.scan_done) state_next = msfbr_pkg::ST_EMIT;
      msfbr_pkg::ST_EMIT:      if (out_fire && stat.emit_last) state_next = msfbr_pkg::ST_DONE;
      msfbr_pkg::ST_DONE:      state_next = msfbr_pkg::ST_LOAD;
      default:                 state_next = msfbr_pkg::ST_LOAD;
    endcase
    if (state == msfbr_pkg::ST_UF_FIND_A && stat.uf_done) state_next = msfbr_pkg::ST_SCAN;
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      msfbr_pkg::ST_LOAD:      begin in_ready = 1'b1; cmd.load = in_fire; end
      msfbr_pkg::ST_CLEAR:     cmd.clear = 1'b1;
      msfbr_pkg::ST_SORT:      cmd.sort_step = 1'b1;
      msfbr_pkg::ST_UF_FIND_A: cmd.find_a = 1'b1;
      msfbr_pkg::ST_UF_FIND_B: cmd.find_b = 1'b1;
      msfbr_pkg::ST_UF_JOIN:   cmd.join_step = 1'b1;
      msfbr_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
      msfbr_pkg::ST_EMIT:      begin out_valid = 1'b1; cmd.emit_step = out_fire; end
      msfbr_pkg::ST_DONE:      cmd.finish = 1'b1;
      default:                 cmd = '0;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != msfbr_pkg::ST_LOAD) |-> !in_ready) else $error("accept while busy");
  a_emit_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == msfbr_pkg::ST_EMIT) |-> ($past(state) == msfbr_pkg::ST_SCAN ||
     $past(state) == msfbr_pkg::ST_EMIT)) else $error("emit entered early");
  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !cmd.finish) else $error("double finish");
endmodule

FILE: hdl/max_spanning_forest_budget_removal.sv
// Top level: maximum spanning forest with budgeted removal of cycle edges.
// channel | dir | handshake          | payload
// s_axis  | in  | s_axis_tvalid/ready| tdata {weight,end_two,end_one}, tlast final_edge
// m_axis  | out | m_axis_tvalid/ready| tdata {total,number,has_edge}, tlast run_end
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
// Edges load one per cycle while s_axis_tready is high. After the final request the
// sets are cleared, the insertion sort orders the edges by falling weight, each union-find
// step walks leader chains one hop per cycle and then joins, and the scan follows.
// Results leave one per cycle as m_axis_tready allows; then the block returns to loading.
// s_axis_tready stays low from the final request until the answer has left.
// Reset returns to loading; the sets are cleared after each final request.
module max_spanning_forest_budget_removal #(
  parameter int MAX_NODES   = msfbr_pkg::MaxNodesDef,
  parameter int MAX_EDGES   = msfbr_pkg::MaxEdgesDef,
  parameter int WEIGHT_BITS = msfbr_pkg::WeightBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // end_one[5:0], end_two[11:6], edge_weight[43:12]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // has_edge[0], chosen_number[6:1], chosen_total[12:7]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [msfbr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  msfbr_pkg::cmd_t  cmd;
  msfbr_pkg::stat_t stat;
  logic [5:0]  node_count;
  logic [62:0] cost_budget;
  logic has_edge;
  logic [5:0] chosen_number, chosen_total;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 6'd32;
      cost_budget <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        msfbr_pkg::CfgNodeCount:  node_count <= cfg_data[5:0];
        msfbr_pkg::CfgCostBudget: cost_budget <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  msfbr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready), .in_last(s_axis_tlast),
    .out_fire(m_axis_tvalid && m_axis_tready), .stat(stat), .cmd(cmd),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  msfbr_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES),
                   .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .node_count(node_count), .cost_budget(cost_budget),
    .end_one(s_axis_tdata[5:0]), .end_two(s_axis_tdata[11:6]),
    .edge_weight(s_axis_tdata[43:12]),
    .has_edge(has_edge), .chosen_number(chosen_number),
    .chosen_total(chosen_total), .run_end(m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, chosen_total, chosen_number, has_edge};

  logic unused_top;
  assign unused_top = ^{s_axis_tdata[47:44], cfg_data[63]};
endmodule

FILE: sim/msfbr_checker.sv
// Checker: watches the edge, result and register channels, predicts and compares answers.
module msfbr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [msfbr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic       has_edge;
    logic [5:0] number;
    logic [5:0] total;
    logic       last;
  } answer_t;

  answer_t    answer_q[$];
  logic [5:0] nodes_reg;
  logic [62:0] budget_reg;
  logic [31:0] wts[32];
  logic [4:0] end_a[32];
  logic [4:0] end_b[32];
  int         loaded;
  int         leader[32];
  int         sz[32];

  function automatic logic [4:0] clamp_vert(logic [5:0] v, int n);
    int x;
    x = v;
    if (x < 1) x = 1;
    if (x > n) x = n;
    return 5'(x - 1);
  endfunction

  function automatic int find_root(int v);
    int r;
    int cur;
    int nxt;
    r = v;
    while (leader[r] != r) r = leader[r];
    cur = v;
    while (cur != r) begin
      nxt = leader[cur];
      leader[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  task automatic predict_forest();
    int order[32];
    bit removable[32];
    int i, j, e, ra, rb, t, total, k;
    logic [63:0] spent, sum;
    logic [31:0] mask;
    answer_t a;
    for (i = 0; i < 32; i++) begin
      leader[i] = i;
      sz[i] = 1;
    end
    for (i = 0; i < loaded; i++) begin
      j = i;
      while (j > 0 && wts[order[j-1]] < wts[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < loaded; i++) begin
      e = order[i];
      ra = find_root(end_a[e]);
      rb = find_root(end_b[e]);
      removable[i] = (ra == rb);
      if (ra != rb) begin
        if (sz[ra] > sz[rb]) begin
          t = ra; ra = rb; rb = t;
        end
        leader[ra] = rb;
        sz[rb] += sz[ra];
      end
    end
    spent = 0;
    mask = 0;
    for (i = loaded; i > 0; i--) begin
      if (removable[i-1]) begin
        e = order[i-1];
        sum = spent + wts[e];
        if (sum < spent) sum = '1;
        if (sum <= {1'b0, budget_reg}) begin
          spent = sum;
          mask[e] = 1'b1;
        end
      end
    end
    total = $countones(mask);
    if (total == 0) begin
      a = '{1'b0, 6'd0, 6'd0, 1'b1};
      answer_q.insert(answer_q.size(), a);
    end else begin
      k = 0;
      for (i = 0; i < loaded; i++) begin
        if (mask[i]) begin
          k++;
          a = '{1'b1, 6'(i + 1), 6'(total), k == total};
          answer_q.insert(answer_q.size(), a);
        end
      end
    end
    loaded = 0;
  endtask

  always @(posedge clk) begin
    answer_t got;
    answer_t exp_a;
    int n;
    if (rst) begin
      nodes_reg  <= 6'd32;
      budget_reg <= '0;
      loaded = 0;
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == msfbr_pkg::CfgNodeCount) nodes_reg <= cfg_data[5:0];
        else if (cfg_index == msfbr_pkg::CfgCostBudget) budget_reg <= cfg_data[62:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n = nodes_reg;
        if (n < 1) n = 1;
        if (n > 32) n = 32;
        if (loaded < 32) begin
          wts[loaded]   = s_axis_tdata[43:12];
          end_a[loaded] = clamp_vert(s_axis_tdata[5:0], n);
          end_b[loaded] = clamp_vert(s_axis_tdata[11:6], n);
          loaded++;
        end
        if (s_axis_tlast) predict_forest();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[12:7], m_axis_tlast};
        if (answer_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answer_q.pop_front();
          if (got !== exp_a) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", exp_a, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = answer_q.size();
endmodule

FILE: sim/tb.sv
// Testbench top: drives graphs, registers and stalls, and gives the verdict.
module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [msfbr_pkg::CfgIdxW-1:0] cfg_index = msfbr_pkg::CfgNodeCount;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          send_idle = 0;
  int          recv_stall = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  max_spanning_forest_budget_removal DUT (.*);

  msfbr_checker checker_i (.*);

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  task automatic send_edge(logic [5:0] a, logic [5:0] b, logic [31:0] w, logic fin);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, w, b, a};
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [msfbr_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_graph(int nodes, int max_len, bit wide_w);
    int len;
    len = $urandom_range(max_len, 1);
    for (int i = 0; i < len; i++)
      send_edge(6'($urandom_range(nodes + 1)), 6'($urandom_range(nodes + 1)),
                wide_w ? $urandom : 32'($urandom_range(40)), i == len - 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: triangle, self loop, ties, extremes, overflow of edge store
    write_reg(msfbr_pkg::CfgCostBudget, 64'd100);
    send_edge(6'd1, 6'd2, 32'd5, 1'b0);
    send_edge(6'd2, 6'd3, 32'd5, 1'b0);
    send_edge(6'd3, 6'd1, 32'd5, 1'b1);
    send_edge(6'd4, 6'd4, 32'd7, 1'b1);
    send_edge(6'd0, 6'd63, 32'hffffffff, 1'b0);
    send_edge(6'd63, 6'd0, 32'hffffffff, 1'b1);
    write_reg(msfbr_pkg::CfgCostBudget, 64'h7fffffffffffffff);
    send_edge(6'd1, 6'd1, 32'hffffffff, 1'b0);
    send_edge(6'd1, 6'd1, 32'hffffffff, 1'b1);
    write_reg(msfbr_pkg::CfgNodeCount, 64'd0);
    send_edge(6'd5, 6'd9, 32'd3, 1'b1);
    write_reg(msfbr_pkg::CfgNodeCount, 64'd63);
    for (int i = 0; i < 34; i++)
      send_edge(6'(i % 34), 6'((i * 7) % 40), 32'(i * 3), i == 33);
    write_reg(msfbr_pkg::CfgCostBudget, 64'd0);
    send_edge(6'd2, 6'd2, 32'd0, 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 25) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 60 : 25) : 0;
      write_reg(msfbr_pkg::CfgNodeCount, 64'($urandom_range(32, 1)));
      write_reg(msfbr_pkg::CfgCostBudget,
                ph == 0 ? 64'h7fffffffffffffff : 64'($urandom_range(200)));
      for (int g = 0; g < 9; g++) random_graph($urandom_range(32, 2), 8, g % 4 == 0);
      write_reg(msfbr_pkg::CfgNodeCount, 64'd32);
      random_graph(32, 34, 1'b1);
    end
    drain();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
